// File: rtl/gfc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gfc_pkg
// Shared widths, codes, constants and helpers of the gravimetric fill
// controller.
// ----------------------------------------------------------------------------
package gfc_pkg;

  localparam int WEIGHT_BITS = 18;
  localparam int TGT_W       = 17;
  localparam int SPD_W       = 7;
  localparam int GAIN_W      = 7;
  localparam int DUTY_W      = 10;
  localparam int CNT_W       = 16;
  localparam int TIMER_W     = 10;
  localparam int ACT_W       = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int PROD_W      = 11;
  localparam int ERR_W       = (((TGT_W + 1) > WEIGHT_BITS) ? (TGT_W + 1) : WEIGHT_BITS) + 1;

  localparam int RAMP_TICKS  = 2;
  localparam int SETTLE_MS   = 1000;

  localparam int ERR_CLAMP   = 15;
  localparam int DUTY_FLOOR  = 200;
  localparam int DUTY_MAX    = 999;
  localparam int DUTY_LIMIT  = 1000;
  localparam int BOTTLE_MIN  = 5;
  localparam int SETTLE_TOL  = 3;
  localparam int DUTY_STEP   = 10;

  typedef enum logic [2:0] {
    PH_IDLE          = 3'd0,
    PH_RAMP          = 3'd1,
    PH_FILL          = 3'd2,
    PH_AWAIT_REMOVAL = 3'd3,
    PH_AWAIT_BOTTLE  = 3'd4,
    PH_CONFIRM       = 3'd5
  } phase_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_SAMPLE    = 3'd0,
    ACT_TICK      = 3'd1,
    ACT_PRESS     = 3'd2,
    ACT_CLR_COUNT = 3'd3,
    ACT_CLR_TARE  = 3'd4
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET     = 3'd0,
    CFG_MAX_SPEED  = 3'd1,
    CFG_GAIN       = 3'd2,
    CFG_TARE_EN    = 3'd3,
    CFG_CONTINUOUS = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic              done;
    logic [DUTY_W-1:0] duty;
  } fill_duty_t;

  function automatic logic [DUTY_W-1:0] clamp_duty(input logic [PROD_W-1:0] v);
    logic [DUTY_W-1:0] r;
    if (v >= PROD_W'(DUTY_LIMIT)) begin
      r = DUTY_W'(DUTY_MAX);
    end else if (v == '0) begin
      r = DUTY_W'(1);
    end else begin
      r = v[DUTY_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/gravimetric_fill_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gravimetric_fill_controller
// Scale-driven bottle filler: tare, pump ramp, proportional fill and
// continuous refill with bottle settle check.
//
//   channel  dir  handshake              payload
//   in       in   in_valid_i/in_stall_o  action_i, raw_weight_i
//   out      out  out_valid_o/out_stall_i pump_duty_o, net_weight_o,
//                                        fill_count_o, phase_o, start_refused_o
//   cfg      in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One beat per cycle while in_stall_o is low: state updates in the
// accept cycle, result valid the next cycle from the state registers.
// in_stall_o rises only while a result is held and out_stall_i is high.
// One state/result register rank. Reset is immediate, no clearing pass.
// ----------------------------------------------------------------------------
module gravimetric_fill_controller (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,

  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic        [gfc_pkg::ACT_W-1:0]       action_i,
  input  logic signed [gfc_pkg::WEIGHT_BITS-1:0] raw_weight_i,

  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic        [gfc_pkg::DUTY_W-1:0]      pump_duty_o,
  output logic signed [gfc_pkg::WEIGHT_BITS-1:0] net_weight_o,
  output logic        [gfc_pkg::CNT_W-1:0]       fill_count_o,
  output logic        [2:0]                      phase_o,
  output logic                                   start_refused_o,

  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic        [gfc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic        [gfc_pkg::TGT_W-1:0]       cfg_data_i
);
  import gfc_pkg::*;

  localparam int W = WEIGHT_BITS;

  // config
  logic [TGT_W-1:0]  target_q;
  logic [SPD_W-1:0]  max_speed_q;
  logic [GAIN_W-1:0] gain_q;
  logic              tare_en_q;
  logic              cont_q;

  // state
  phase_e              phase_q, phase_d;
  logic signed [W-1:0] tare_q, tare_d;
  logic signed [W-1:0] net_q, net_d;
  logic signed [W-1:0] raw_q, raw_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [SPD_W-1:0]    step_q, step_d;
  logic [1:0]          tick_cnt_q, tick_cnt_d;
  logic [DUTY_W-1:0]   duty_q, duty_d;
  logic signed [W-1:0] ref_q, ref_d;
  logic [TIMER_W-1:0]  timer_q, timer_d;
  logic                refused_q;
  logic                out_valid_q;

  logic                in_acc;
  logic                is_sample, is_tick, is_press, is_clr_cnt, is_clr_tare;
  logic signed [W:0]   diff;
  logic signed [W-1:0] net_sat;
  logic signed [W-1:0] net_new;
  logic signed [W+1:0] bottle_lim;
  logic                above_min;
  logic signed [W:0]   dev;
  logic                dev_out;
  logic                net_pos;
  logic [1:0]          tick_inc;
  logic [SPD_W-1:0]    step_inc;
  logic [TIMER_W-1:0]  timer_inc;
  logic                ramp_adv, ramp_end, settle_done;
  logic                both_zero, start_ok, refuse, begin_f, stop;
  phase_e              begin_phase;
  fill_duty_t          fres;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign is_sample   = in_acc && (action_i == ACT_SAMPLE);
  assign is_tick     = in_acc && (action_i == ACT_TICK);
  assign is_press    = in_acc && (action_i == ACT_PRESS);
  assign is_clr_cnt  = in_acc && (action_i == ACT_CLR_COUNT);
  assign is_clr_tare = in_acc && (action_i == ACT_CLR_TARE);

  // net weight, saturated
  assign diff    = {raw_weight_i[W-1], raw_weight_i} - {tare_q[W-1], tare_q};
  assign net_sat = (diff[W] != diff[W-1]) ?
                   (diff[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}}) :
                   diff[W-1:0];
  assign net_new = is_sample ? (tare_en_q ? net_sat : raw_weight_i) : net_q;
  assign net_pos = !net_new[W-1] && (net_new != '0);

  assign bottle_lim = (W+2)'(BOTTLE_MIN) - {{2{tare_q[W-1]}}, tare_q};
  assign above_min  = $signed({{2{net_new[W-1]}}, net_new}) > bottle_lim;

  assign dev     = {net_new[W-1], net_new} - {ref_q[W-1], ref_q};
  assign dev_out = (dev > (W+1)'(SETTLE_TOL)) || (dev < -$signed((W+1)'(SETTLE_TOL)));

  assign tick_inc    = tick_cnt_q + 2'd1;
  assign step_inc    = step_q + SPD_W'(1);
  assign timer_inc   = timer_q + TIMER_W'(1);
  assign ramp_adv    = is_tick && (phase_q == PH_RAMP) && (tick_inc >= 2'(RAMP_TICKS));
  assign ramp_end    = step_inc >= max_speed_q;
  assign settle_done = is_tick && (phase_q == PH_CONFIRM) && (timer_inc >= TIMER_W'(SETTLE_MS));

  assign both_zero   = (net_q == '0) && (tare_q == '0);
  assign start_ok    = is_press && (phase_q == PH_IDLE) && !both_zero;
  assign refuse      = is_press && (phase_q == PH_IDLE) && both_zero;
  assign begin_f     = start_ok || settle_done;
  assign stop        = is_press && ((phase_q == PH_FILL) || (phase_q == PH_AWAIT_REMOVAL) ||
                                    (phase_q == PH_AWAIT_BOTTLE));
  assign begin_phase = (max_speed_q == '0) ? PH_FILL : PH_RAMP;

  gfc_duty u_duty (
    .target_i    (target_q),
    .net_i       (net_new),
    .max_speed_i (max_speed_q),
    .gain_i      (gain_q),
    .res_o       (fres)
  );

  // next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_IDLE: begin
        if (start_ok) phase_d = begin_phase;
      end
      PH_RAMP: begin
        if (ramp_adv && ramp_end) phase_d = PH_FILL;
      end
      PH_FILL: begin
        if (is_sample && fres.done) begin
          if (cont_q) phase_d = net_pos ? PH_AWAIT_REMOVAL : PH_AWAIT_BOTTLE;
          else        phase_d = PH_IDLE;
        end else if (stop) begin
          phase_d = PH_IDLE;
        end
      end
      PH_AWAIT_REMOVAL: begin
        if (is_sample && !net_pos) phase_d = PH_AWAIT_BOTTLE;
        else if (stop)             phase_d = PH_IDLE;
      end
      PH_AWAIT_BOTTLE: begin
        if (is_sample && above_min) phase_d = PH_CONFIRM;
        else if (stop)              phase_d = PH_IDLE;
      end
      PH_CONFIRM: begin
        if (is_sample && dev_out) phase_d = PH_AWAIT_BOTTLE;
        else if (settle_done)     phase_d = begin_phase;
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  // datapath next values
  always_comb begin
    tare_d     = tare_q;
    net_d      = net_new;
    raw_d      = is_sample ? raw_weight_i : raw_q;
    count_d    = count_q;
    step_d     = step_q;
    tick_cnt_d = tick_cnt_q;
    duty_d     = duty_q;
    ref_d      = ref_q;
    timer_d    = timer_q;

    if (is_sample && (phase_q == PH_FILL)) begin
      if (fres.done) begin
        duty_d  = DUTY_W'(1);
        count_d = count_q + CNT_W'(1);
      end else begin
        duty_d  = fres.duty;
      end
    end
    if (is_sample && (phase_q == PH_AWAIT_BOTTLE) && above_min) begin
      ref_d   = net_new;
      timer_d = '0;
    end
    if (is_tick && (phase_q == PH_RAMP)) begin
      tick_cnt_d = tick_inc;
      if (ramp_adv) begin
        tick_cnt_d = '0;
        step_d     = step_inc;
        if (!ramp_end) duty_d = clamp_duty(PROD_W'(step_inc) * PROD_W'(DUTY_STEP));
      end
    end
    if (is_tick && (phase_q == PH_CONFIRM)) timer_d = timer_inc;
    if (stop) duty_d = DUTY_W'(1);
    if (is_clr_cnt && (phase_q == PH_IDLE)) count_d = '0;
    if (is_clr_tare && (phase_q == PH_IDLE)) tare_d = '0;
    if (begin_f) begin
      tare_d     = tare_en_q ? raw_q : '0;
      step_d     = '0;
      tick_cnt_d = '0;
      duty_d     = DUTY_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      tare_q      <= '0;
      net_q       <= '0;
      raw_q       <= '0;
      count_q     <= '0;
      step_q      <= '0;
      tick_cnt_q  <= '0;
      duty_q      <= DUTY_W'(1);
      ref_q       <= '0;
      timer_q     <= '0;
      refused_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q    <= phase_d;
        tare_q     <= tare_d;
        net_q      <= net_d;
        raw_q      <= raw_d;
        count_q    <= count_d;
        step_q     <= step_d;
        tick_cnt_q <= tick_cnt_d;
        duty_q     <= duty_d;
        ref_q      <= ref_d;
        timer_q    <= timer_d;
        refused_q  <= refuse;
      end
      if (in_acc)            out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= TGT_W'(200);
      max_speed_q <= SPD_W'(80);
      gain_q      <= GAIN_W'(70);
      tare_en_q   <= 1'b1;
      cont_q      <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_TARGET:     target_q    <= cfg_data_i;
        CFG_MAX_SPEED:  max_speed_q <= cfg_data_i[SPD_W-1:0];
        CFG_GAIN:       gain_q      <= cfg_data_i[GAIN_W-1:0];
        CFG_TARE_EN:    tare_en_q   <= cfg_data_i[0];
        CFG_CONTINUOUS: cont_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pump_duty_o     = duty_q;
  assign net_weight_o    = net_q;
  assign fill_count_o    = count_q;
  assign phase_o         = phase_q;
  assign start_refused_o = refused_q;

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (duty_q != '0) && (duty_q < DUTY_W'(DUTY_LIMIT)))
    else $error("pump duty out of range");

  a_pump_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((phase_q != PH_RAMP) && (phase_q != PH_FILL)) |-> (duty_q == DUTY_W'(1)))
    else $error("pump running outside ramp or fill");

  a_refuse_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    refused_q |-> (phase_q == PH_IDLE))
    else $error("refused start outside idle");

  a_count_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (($past(phase_q) == PH_FILL) || ($past(phase_q) == PH_IDLE)))
    else $error("fill count changed outside fill or idle");

endmodule
`default_nettype wire

// File: rtl/gfc_duty.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gfc_duty
// Proportional fill step: weight error, completion test and clamped duty.
// ----------------------------------------------------------------------------
module gfc_duty (
  input  logic        [gfc_pkg::TGT_W-1:0]       target_i,
  input  logic signed [gfc_pkg::WEIGHT_BITS-1:0] net_i,
  input  logic        [gfc_pkg::SPD_W-1:0]       max_speed_i,
  input  logic        [gfc_pkg::GAIN_W-1:0]      gain_i,
  output gfc_pkg::fill_duty_t                    res_o
);
  import gfc_pkg::*;

  logic signed [ERR_W-1:0]  tgt_s;
  logic signed [ERR_W-1:0]  net_s;
  logic signed [ERR_W-1:0]  err;
  logic                     err_big;
  logic [3:0]               err_c;
  logic [PROD_W-1:0]        prod;
  logic [PROD_W-1:0]        cap;
  logic [PROD_W-1:0]        lim;
  logic [PROD_W-1:0]        lim_f;

  assign tgt_s   = {{(ERR_W-TGT_W){1'b0}}, target_i};
  assign net_s   = {{(ERR_W-WEIGHT_BITS){net_i[WEIGHT_BITS-1]}}, net_i};
  assign err     = tgt_s - net_s;

  assign err_big = !err[ERR_W-1] && (err > ERR_W'(ERR_CLAMP));
  assign err_c   = err_big ? 4'(ERR_CLAMP) : err[3:0];

  assign prod    = PROD_W'(err_c) * PROD_W'(gain_i);
  assign cap     = PROD_W'(max_speed_i) * PROD_W'(DUTY_STEP);
  assign lim     = (prod > cap) ? cap : prod;
  assign lim_f   = ((lim != '0) && (lim < PROD_W'(DUTY_FLOOR))) ? PROD_W'(DUTY_FLOOR) : lim;

  assign res_o.done = err[ERR_W-1] || (err == '0);
  assign res_o.duty = clamp_duty(lim_f);

endmodule
`default_nettype wire
